>>> hdl/pisv_pkg.sv
// shared types and codes for the page image store with verify
`default_nettype none

package pisv_pkg;

  // command codes on the input channel
  localparam logic [1:0] CMD_BEGIN  = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_COMMIT = 2'd2;
  localparam logic [1:0] CMD_VERIFY = 2'd3;

  // status codes on the result channel
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic begin_en;
    logic write_en;
    logic commit_en;
    logic scan_start;
    logic scan_en;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sess_open;
    logic committed;
    logic begin_ok;
    logic write_ok;
    logic all_used;
    logic scan_done;
    logic sum_match;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/page_image_store_verify.sv
// top level of the page image store with checksum verify
//
//  channel | signals                                                  | direction
//  --------+----------------------------------------------------------+----------
//  input   | in_valid in_ready in_cmd in_page_count in_page_index     | in
//          | in_byte_offset in_data_byte                              |
//  result  | out_valid out_ready out_status                           | out
//
// results of begin, write, commit and a rejected verify land in an output
// register the cycle after the transaction, so writes stream at one per cycle
// while out_ready stays high.
// a verify walks the stored image one byte per cycle through the store's single
// read port, with input held off meanwhile.
// reset clears session state and the used map; the page store is not cleared.
// a new transaction is taken only while the result register is empty or draining.
`default_nettype none

module page_image_store_verify #(
  parameter int MAX_PAGES  = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [6:0]  in_page_count,
  input  wire logic [5:0]  in_page_index,
  input  wire logic [11:0] in_byte_offset,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status
);
  import pisv_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  // controller
  pisv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .dcmd       (dcmd),
    .stat       (stat)
  );

  // datapath
  pisv_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dcmd),
    .stat        (stat),
    .page_count  (in_page_count),
    .page_index  (in_page_index),
    .byte_offset (in_byte_offset),
    .data_byte   (in_data_byte)
  );

endmodule

`default_nettype wire

>>> hdl/pisv_dp.sv
// datapath: page store memory, session state, used map, running and verify sums
`default_nettype none

module pisv_dp #(
  parameter int MAX_PAGES  = 64,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pisv_pkg::dp_cmd_t cmd,
  output pisv_pkg::dp_stat_t     stat,
  input  wire logic [6:0]        page_count,
  input  wire logic [5:0]        page_index,
  input  wire logic [11:0]       byte_offset,
  input  wire logic [7:0]        data_byte
);
  import pisv_pkg::*;

  localparam int DEPTH = MAX_PAGES * PAGE_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam logic [16:0] PB_W     = 17'(PAGE_BYTES);
  localparam logic [16:0] LAST_OFF = 17'(PAGE_BYTES - 1);
  localparam logic [6:0]  MAX_W    = 7'(MAX_PAGES);

  logic [7:0]           mem [DEPTH];
  logic [MAX_PAGES-1:0] used_r;
  logic [6:0]           page_total_r;
  logic [63:0]          run_sum_r;
  logic                 open_r;
  logic                 committed_r;
  logic [CW-1:0]        scan_end_r;
  logic [CW-1:0]        addr_r;
  logic                 rd_vld_r;
  logic [7:0]           rd_data_r;
  logic [63:0]          acc_r;

  logic [AW-1:0]        wr_addr;
  logic                 issue_done;
  logic                 rd_issue;
  logic                 all_used;
  logic [PW-1:0]        page_sel;

  // address of the byte being written
  assign wr_addr  = AW'(page_index) * AW'(PAGE_BYTES) + AW'(byte_offset);
  assign page_sel = page_index[PW-1:0];

  // scan issue control
  assign issue_done = (addr_r == scan_end_r);
  assign rd_issue   = cmd.scan_en && !issue_done;

  // every page of the image marked used
  always_comb begin
    all_used = 1'b1;
    for (int p = 0; p < MAX_PAGES; p++) begin
      if ((7'(p) < page_total_r) && !used_r[p]) begin
        all_used = 1'b0;
      end
    end
  end

  // status towards the controller
  always_comb begin
    stat.sess_open = open_r;
    stat.committed = committed_r;
    stat.begin_ok  = !open_r && (page_count != 7'd0) && (page_count <= MAX_W);
    stat.write_ok  = open_r && ({1'b0, page_index} < page_total_r)
                     && (17'(byte_offset) < PB_W);
    stat.all_used  = all_used;
    stat.scan_done = issue_done && !rd_vld_r;
    stat.sum_match = (acc_r == run_sum_r);
  end

  // page store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      mem[wr_addr] <= data_byte;
    end
    if (rd_issue) begin
      rd_data_r <= mem[addr_r[AW-1:0]];
    end
  end

  // session state, used map and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      page_total_r <= '0;
      run_sum_r    <= '0;
      open_r       <= 1'b0;
      committed_r  <= 1'b0;
      scan_end_r   <= '0;
    end else if (cmd.begin_en) begin
      used_r       <= '0;
      page_total_r <= page_count;
      run_sum_r    <= '0;
      open_r       <= 1'b1;
      committed_r  <= 1'b0;
      scan_end_r   <= CW'(page_count) * CW'(PAGE_BYTES);
    end else if (cmd.write_en) begin
      run_sum_r <= run_sum_r + {56'd0, data_byte};
      if (17'(byte_offset) == LAST_OFF) begin
        used_r[page_sel] <= 1'b1;
      end
    end else if (cmd.commit_en) begin
      open_r      <= 1'b0;
      committed_r <= 1'b1;
    end
  end

  // verify scan: address counter, read valid and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
      acc_r    <= '0;
    end else if (cmd.scan_start) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      rd_vld_r <= rd_issue;
      if (rd_issue) begin
        addr_r <= addr_r + CW'(1);
      end
      if (rd_vld_r) begin
        acc_r <= acc_r + {56'd0, rd_data_r};
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/pisv_ctrl.sv
// controller: handshakes, command decode, verify sequencing and result register
`default_nettype none

module pisv_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output pisv_pkg::dp_cmd_t       dcmd,
  input  wire pisv_pkg::dp_stat_t stat
);
  import pisv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic       take;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign take      = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  // decode and next state
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    dcmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          out_valid_nxt = 1'b1;
          case (in_cmd)
            CMD_BEGIN: begin
              dcmd.begin_en  = stat.begin_ok;
              out_status_nxt = stat.begin_ok ? ST_OK : ST_REJECT;
            end
            CMD_WRITE: begin
              dcmd.write_en  = stat.write_ok;
              out_status_nxt = stat.write_ok ? ST_OK : ST_REJECT;
            end
            CMD_COMMIT: begin
              if (!stat.sess_open) begin
                out_status_nxt = ST_REJECT;
              end else if (!stat.all_used) begin
                out_status_nxt = ST_MISSING;
              end else begin
                dcmd.commit_en = 1'b1;
                out_status_nxt = ST_OK;
              end
            end
            CMD_VERIFY: begin
              if (!stat.committed) begin
                out_status_nxt = ST_REJECT;
              end else if (!stat.all_used) begin
                out_status_nxt = ST_MISSING;
              end else begin
                // result follows when the scan ends
                out_valid_nxt   = 1'b0;
                dcmd.scan_start = 1'b1;
                state_nxt       = S_SCAN;
              end
            end
            default: begin
              out_status_nxt = ST_REJECT;
            end
          endcase
        end
      end
      S_SCAN: begin
        dcmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat.sum_match ? ST_OK : ST_MISMATCH;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/pisv_chk.sv
// port level checks for the page image store, bound to the top level
`default_nettype none

module pisv_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_cmd,
  input wire logic [6:0]  in_page_count,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status
);
  import pisv_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  // no transaction is taken while the result register is blocked
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("transaction taken with result register full");

  // a write answers in the next cycle with ok or rejected
  a_write_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_WRITE
    |=> out_valid && (out_status == ST_OK || out_status == ST_REJECT))
    else $error("bad write response");

  // a begin with zero pages is rejected at once
  a_begin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_BEGIN && in_page_count == 7'd0
    |=> out_valid && out_status == ST_REJECT)
    else $error("zero page begin not rejected");

  // commit never reports a checksum mismatch
  a_commit_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_COMMIT
    |=> out_valid && out_status != ST_MISMATCH)
    else $error("bad commit response");

endmodule

bind page_image_store_verify pisv_chk u_pisv_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_cmd        (in_cmd),
  .in_page_count (in_page_count),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status)
);

`default_nettype wire
